FILE: src/nmb_pkg.sv
// Shared types and constants for the 3x3 neighbour-mean blur.
package nmb_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);

  localparam int CHAN_W      = 8;
  localparam int SIZE_W      = 11;
  localparam int TAG_W       = 10;
  localparam int CFG_IDX_W   = 4;
  localparam int NB_COUNT    = 8;
  localparam int NB_SHIFT    = 3;

  // The queue depth must be a power of two so that the pointers wrap by themselves.
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // One classified pixel: its neighbourhood, its position and which results it owes.
  typedef struct packed {
    pixel_t [NB_COUNT-1:0] nb;
    pixel_t                center;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic                  has_prev;
    logic                  interior;
    logic                  has_edge;
    logic                  has_self;
    logic                  row_end;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } beat_t;

endpackage

FILE: src/nmb_pix_if.sv
// Channel carrying one input pixel per beat.
interface nmb_pix_if;
  logic                      valid;
  logic                      ready;
  logic [nmb_pkg::CHAN_W-1:0] red;
  logic [nmb_pkg::CHAN_W-1:0] green;
  logic [nmb_pkg::CHAN_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

FILE: src/nmb_res_if.sv
// Channel carrying one tagged result pixel per beat.
interface nmb_res_if;
  logic                      valid;
  logic                      ready;
  logic [nmb_pkg::CHAN_W-1:0] out_red;
  logic [nmb_pkg::CHAN_W-1:0] out_green;
  logic [nmb_pkg::CHAN_W-1:0] out_blue;
  logic [nmb_pkg::TAG_W-1:0]  pixel_row;
  logic [nmb_pkg::TAG_W-1:0]  pixel_col;
  logic                      frame_last;

  modport source (output valid, out_red, out_green, out_blue, pixel_row, pixel_col,
                  frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, pixel_row, pixel_col,
                  frame_last, output ready);
endinterface

FILE: src/nmb_cfg_if.sv
// Configuration write channel: register index and data per beat.
interface nmb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [nmb_pkg::CFG_IDX_W-1:0] index;
  logic [nmb_pkg::SIZE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/nmb_front.sv
// Front end: size registers, raster counters, line stores, window and classification.
module nmb_front (
  input  logic            clk,
  input  logic            rst,
  nmb_pix_if.sink         pixels,
  nmb_cfg_if.sink         cfg,
  output nmb_pkg::beat_t  push,
  input  logic            push_ready
);

  localparam int COL_W = nmb_pkg::COL_W;
  localparam int ROW_W = nmb_pkg::ROW_W;

  logic [nmb_pkg::SIZE_W-1:0] image_width;
  logic [nmb_pkg::SIZE_W-1:0] image_height;
  logic [COL_W-1:0]           col_counter;
  logic [ROW_W-1:0]           row_counter;

  nmb_pkg::pixel_t older_line [nmb_pkg::MAX_WIDTH];
  nmb_pkg::pixel_t newer_line [nmb_pkg::MAX_WIDTH];
  nmb_pkg::pixel_t rd_top;
  nmb_pkg::pixel_t rd_mid;

  nmb_pkg::pixel_t win [6];

  logic             s1_valid;
  nmb_pkg::pixel_t  s1_cur;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_has_prev;
  logic             s1_interior;
  logic             s1_has_edge;
  logic             s1_has_self;
  logic             s1_row_end;
  logic             fwd;
  nmb_pkg::pixel_t  fwd_top;
  nmb_pkg::pixel_t  fwd_mid;

  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;
  logic             row_end;
  logic             last_row;
  logic             accept;
  logic             s1_fire;
  logic             s1_owes;
  nmb_pkg::pixel_t  cur;
  nmb_pkg::pixel_t  top;
  nmb_pkg::pixel_t  mid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= nmb_pkg::RESET_WIDTH;
      image_height <= nmb_pkg::RESET_HEIGHT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        nmb_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        nmb_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Effective sizes minus one, with zero taken as one and large values clamped.
  always_comb begin
    if (image_width == '0) begin
      w_m1 = '0;
    end else if (32'(image_width) > nmb_pkg::MAX_WIDTH) begin
      w_m1 = COL_W'(nmb_pkg::MAX_WIDTH - 1);
    end else begin
      w_m1 = COL_W'(32'(image_width) - 1);
    end
    if (image_height == '0) begin
      h_m1 = '0;
    end else if (32'(image_height) > nmb_pkg::MAX_HEIGHT) begin
      h_m1 = ROW_W'(nmb_pkg::MAX_HEIGHT - 1);
    end else begin
      h_m1 = ROW_W'(32'(image_height) - 1);
    end
  end

  assign row_end  = col_counter >= w_m1;
  assign last_row = row_counter >= h_m1;

  assign s1_owes       = s1_has_prev | s1_has_edge | s1_has_self;
  assign s1_fire       = s1_valid & (~s1_owes | push_ready);
  assign pixels.ready  = ~s1_valid | s1_fire;
  assign accept        = pixels.valid & pixels.ready;

  assign cur = '{red: pixels.red, green: pixels.green, blue: pixels.blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      col_counter <= '0;
      row_counter <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_counter <= '0;
        row_counter <= last_row ? '0 : row_counter + ROW_W'(1);
      end else begin
        col_counter <= col_counter + COL_W'(1);
      end
    end
  end

  // Line stores: read at acceptance, written back when the pixel leaves stage one.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_top <= older_line[col_counter];
      rd_mid <= newer_line[col_counter];
    end
    if (s1_fire) begin
      older_line[s1_col] <= mid;
      newer_line[s1_col] <= s1_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixels.ready) begin
      s1_valid <= pixels.valid;
    end
  end

  // A one-pixel row rereads the column just being written, so that write is bypassed.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur      <= cur;
      s1_col      <= col_counter;
      s1_row      <= row_counter;
      s1_row_end  <= row_end;
      s1_has_prev <= (row_counter >= ROW_W'(1)) && (col_counter >= COL_W'(1));
      s1_has_edge <= (row_counter >= ROW_W'(1)) && row_end;
      s1_has_self <= last_row;
      s1_interior <= (row_counter >= ROW_W'(2)) && (col_counter >= COL_W'(2)) &&
                     (row_counter <= h_m1) && (col_counter <= w_m1);
      fwd         <= s1_valid && (s1_col == col_counter);
      fwd_top     <= mid;
      fwd_mid     <= s1_cur;
    end
  end

  assign top = fwd ? fwd_top : rd_top;
  assign mid = fwd ? fwd_mid : rd_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        win[k] <= '0;
      end
    end else if (s1_fire) begin
      win[1] <= win[0];
      win[0] <= top;
      win[3] <= win[2];
      win[2] <= mid;
      win[5] <= win[4];
      win[4] <= s1_cur;
    end
  end

  always_comb begin
    push.valid          = s1_valid & s1_owes;
    push.entry.nb[0]    = win[1];
    push.entry.nb[1]    = win[0];
    push.entry.nb[2]    = top;
    push.entry.nb[3]    = win[3];
    push.entry.nb[4]    = mid;
    push.entry.nb[5]    = win[5];
    push.entry.nb[6]    = win[4];
    push.entry.nb[7]    = s1_cur;
    push.entry.center   = win[2];
    push.entry.row      = s1_row;
    push.entry.col      = s1_col;
    push.entry.has_prev = s1_has_prev;
    push.entry.interior = s1_interior;
    push.entry.has_edge = s1_has_edge;
    push.entry.has_self = s1_has_self;
    push.entry.row_end  = s1_row_end;
  end

endmodule

FILE: src/nmb_queue.sv
// Short register queue between the front end and the result sequencer.
module nmb_queue (
  input  logic            clk,
  input  logic            rst,
  input  nmb_pkg::beat_t  push,
  output logic            push_ready,
  output nmb_pkg::beat_t  head,
  input  logic            pop_ready
);

  localparam int PTR_W = $clog2(nmb_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(nmb_pkg::QUEUE_DEPTH + 1);

  nmb_pkg::entry_t entries [nmb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign push_ready = count < CNT_W'(nmb_pkg::QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.entry = entries[rd_ptr];

  assign do_push = push.valid & push_ready;
  assign do_pop  = head.valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.entry;
    end
  end

endmodule

FILE: src/nmb_back.sv
// Back end: neighbour mean and the ordered issue of up to three results per pixel.
module nmb_back (
  input  logic            clk,
  input  logic            rst,
  input  nmb_pkg::beat_t  head,
  output logic            pop_ready,
  nmb_res_if.source       results
);

  localparam int SUM_W = nmb_pkg::CHAN_W + $clog2(nmb_pkg::NB_COUNT);

  function automatic nmb_pkg::pixel_t mean8(input nmb_pkg::pixel_t [nmb_pkg::NB_COUNT-1:0] nb);
    logic [SUM_W-1:0] sr;
    logic [SUM_W-1:0] sg;
    logic [SUM_W-1:0] sb;
    nmb_pkg::pixel_t  res;
    sr = '0;
    sg = '0;
    sb = '0;
    for (int k = 0; k < nmb_pkg::NB_COUNT; k++) begin
      sr = sr + SUM_W'(nb[k].red);
      sg = sg + SUM_W'(nb[k].green);
      sb = sb + SUM_W'(nb[k].blue);
    end
    res.red   = nmb_pkg::CHAN_W'(sr >> nmb_pkg::NB_SHIFT);
    res.green = nmb_pkg::CHAN_W'(sg >> nmb_pkg::NB_SHIFT);
    res.blue  = nmb_pkg::CHAN_W'(sb >> nmb_pkg::NB_SHIFT);
    return res;
  endfunction

  logic [2:0] done;
  logic       out_valid;
  nmb_pkg::pixel_t out_px;
  logic [nmb_pkg::TAG_W-1:0] out_row;
  logic [nmb_pkg::TAG_W-1:0] out_col;
  logic       out_last;

  logic [2:0] pending;
  logic [2:0] sel;
  logic [2:0] rest;
  logic       load;
  nmb_pkg::pixel_t           px_next;
  logic [nmb_pkg::ROW_W-1:0] row_next;
  logic [nmb_pkg::COL_W-1:0] col_next;
  logic                      last_next;

  // Bit 0 is the lagging pixel, bit 1 the row-end border pixel, bit 2 the pixel itself.
  assign pending = {head.entry.has_self, head.entry.has_edge, head.entry.has_prev} & ~done;
  assign sel     = pending & (~pending + 3'd1);
  assign rest    = pending & ~sel;
  assign load    = head.valid & (~out_valid | results.ready);
  assign pop_ready = load & (rest == 3'b000);

  always_comb begin
    px_next   = head.entry.nb[7];
    row_next  = head.entry.row;
    col_next  = head.entry.col;
    last_next = head.entry.row_end;
    if (sel[0]) begin
      px_next   = head.entry.interior ? mean8(head.entry.nb) : head.entry.center;
      row_next  = head.entry.row - nmb_pkg::ROW_W'(1);
      col_next  = head.entry.col - nmb_pkg::COL_W'(1);
      last_next = 1'b0;
    end else if (sel[1]) begin
      px_next   = head.entry.nb[4];
      row_next  = head.entry.row - nmb_pkg::ROW_W'(1);
      last_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        done      <= (rest == 3'b000) ? 3'b000 : (done | sel);
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_px   <= px_next;
      out_row  <= nmb_pkg::TAG_W'(row_next);
      out_col  <= nmb_pkg::TAG_W'(col_next);
      out_last <= last_next;
    end
  end

  assign results.valid      = out_valid;
  assign results.out_red    = out_px.red;
  assign results.out_green  = out_px.green;
  assign results.out_blue   = out_px.blue;
  assign results.pixel_row  = out_row;
  assign results.pixel_col  = out_col;
  assign results.frame_last = out_last;

endmodule

FILE: src/neighbour_mean_blur_3x3.sv
// Accepts one pixel a beat; its results pass through stage one, the queue and the output register.
// Sustained rate is one pixel a cycle unless results stall; the result sequencer issues one result
// a cycle, so a pixel owing two or three results (row ends, every pixel of the last row) holds it
// until all are issued, and the four-entry queue absorbs short bursts of them.
// Reset clears the counters, the window and the queue and loads the sizes 640 by 480; the line
// stores are not cleared and need no clearing pass.
module neighbour_mean_blur_3x3 (
  input  logic       clk,
  input  logic       rst,
  nmb_pix_if.sink    pixels,
  nmb_res_if.source  results,
  nmb_cfg_if.sink    cfg
);

  nmb_pkg::beat_t push;
  nmb_pkg::beat_t head;
  logic           push_ready;
  logic           pop_ready;

  nmb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixels     (pixels),
    .cfg        (cfg),
    .push       (push),
    .push_ready (push_ready)
  );

  nmb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop_ready  (pop_ready)
  );

  nmb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop_ready (pop_ready),
    .results   (results)
  );

endmodule

FILE: src/nmb_checker.sv
// Port-level checks on the blur's result channel, bound to the top level.
module nmb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        pix_valid,
  input logic                        pix_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [nmb_pkg::CHAN_W-1:0]  out_red,
  input logic [nmb_pkg::CHAN_W-1:0]  out_green,
  input logic [nmb_pkg::CHAN_W-1:0]  out_blue,
  input logic [nmb_pkg::TAG_W-1:0]   pixel_row,
  input logic [nmb_pkg::TAG_W-1:0]   pixel_col,
  input logic                        frame_last
);

  logic seen_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_pixel <= 1'b0;
    end else if (pix_valid && pix_ready) begin
      seen_pixel <= 1'b1;
    end
  end

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(out_red) && $stable(out_green) &&
      $stable(out_blue) && $stable(pixel_row) && $stable(pixel_col) && $stable(frame_last))
    else $error("result beat changed while stalled");

  a_no_result_unprompted: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> seen_pixel)
    else $error("result presented before any pixel was accepted");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid straight after reset");

endmodule

bind neighbour_mean_blur_3x3 nmb_checker u_nmb_checker (
  .clk        (clk),
  .rst        (rst),
  .pix_valid  (pixels.valid),
  .pix_ready  (pixels.ready),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .out_red    (results.out_red),
  .out_green  (results.out_green),
  .out_blue   (results.out_blue),
  .pixel_row  (results.pixel_row),
  .pixel_col  (results.pixel_col),
  .frame_last (results.frame_last)
);

FILE: sim/neighbour_mean_blur_3x3_test.sv
// Self-checking bench for the 3x3 neighbour-mean blur: directed frames, resizes, random frames.
module neighbour_mean_blur_3x3_test;
  import nmb_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 60;
  localparam int MAX_REPORTS  = 40;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_FULL, FILL_CHECKER} fill_t;
  typedef enum logic [1:0] {READY_ALWAYS, READY_MOSTLY, READY_SELDOM, READY_ALTERNATE} ready_style_t;

  typedef struct packed {
    pixel_t           pixel;
    logic [TAG_W-1:0] row;
    logic [TAG_W-1:0] col;
    logic             frame_last;
  } blurred_pixel_t;

  logic clk = 1'b0;
  logic rst;

  nmb_pix_if pixel_bus ();
  nmb_res_if result_bus ();
  nmb_cfg_if config_bus ();

  neighbour_mean_blur_3x3 dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pixel_bus),
    .results (result_bus),
    .cfg     (config_bus)
  );

  always #10 clk = ~clk;

  // Blur predictor state: two stored rows, the 3x2 window of earlier columns, the raster position.
  pixel_t             line_two_up [MAX_WIDTH];
  pixel_t             line_one_up [MAX_WIDTH];
  pixel_t             nbr_win [6];
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [SIZE_W-1:0]  width_setting;
  logic [SIZE_W-1:0]  height_setting;
  blurred_pixel_t     expected_pixels [$];
  blurred_pixel_t     oldest_expected;

  int unsigned mismatch_count = 0;
  int unsigned pixel_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_request = 0;
  logic        bursty = 1'b1;
  logic        offering = 1'b0;

  function automatic int unsigned effective_size(logic [SIZE_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic pixel_t neighbour_mean(pixel_t [NB_COUNT-1:0] nb);
    int unsigned sr, sg, sb;
    int k;
    pixel_t m;
    sr = 0;
    sg = 0;
    sb = 0;
    for (k = 0; k < NB_COUNT; k++) begin
      sr += nb[k].red;
      sg += nb[k].green;
      sb += nb[k].blue;
    end
    m.red   = CHAN_W'(sr >> NB_SHIFT);
    m.green = CHAN_W'(sg >> NB_SHIFT);
    m.blue  = CHAN_W'(sb >> NB_SHIFT);
    return m;
  endfunction

  function automatic void owe(pixel_t px, int unsigned r, int unsigned c, logic last);
    blurred_pixel_t e;
    e.pixel      = px;
    e.row        = TAG_W'(r);
    e.col        = TAG_W'(c);
    e.frame_last = last;
    expected_pixels.push_back(e);
  endfunction

  // Works out the results of one accepted pixel and advances the raster position.
  function automatic void predict_pixel(pixel_t cur);
    int unsigned w, h, i, j, r, c;
    logic row_end, last_row;
    pixel_t top, mid, px;
    pixel_t [NB_COUNT-1:0] nb;
    w = effective_size(width_setting, MAX_WIDTH);
    h = effective_size(height_setting, MAX_HEIGHT);
    j = col_pos % MAX_WIDTH;
    i = row_pos % MAX_HEIGHT;
    row_end  = (j >= w - 1);
    last_row = (i >= h - 1);
    top = line_two_up[j];
    mid = line_one_up[j];
    if (i >= 1 && j >= 1) begin
      r = i - 1;
      c = j - 1;
      px = nbr_win[2];
      // Only pixels whose whole window lies inside the current frame are blurred.
      if (r >= 1 && c >= 1 && r + 1 < h && c + 1 < w) begin
        nb[0] = nbr_win[1];
        nb[1] = nbr_win[0];
        nb[2] = top;
        nb[3] = nbr_win[3];
        nb[4] = mid;
        nb[5] = nbr_win[5];
        nb[6] = nbr_win[4];
        nb[7] = cur;
        px = neighbour_mean(nb);
      end
      owe(px, r, c, 1'b0);
    end
    if (i >= 1 && row_end) owe(mid, i - 1, j, 1'b0);
    if (last_row) owe(cur, i, j, row_end);
    line_two_up[j] = mid;
    line_one_up[j] = cur;
    nbr_win[1] = nbr_win[0];
    nbr_win[0] = top;
    nbr_win[3] = nbr_win[2];
    nbr_win[2] = mid;
    nbr_win[5] = nbr_win[4];
    nbr_win[4] = cur;
    if (row_end) begin
      col_pos = 0;
      row_pos = last_row ? 0 : i + 1;
    end else begin
      col_pos = j + 1;
    end
  endfunction

  function automatic logic at_frame_start();
    return col_pos == 0 && row_pos == 0;
  endfunction

  function automatic pixel_t make_pixel(fill_t fill);
    pixel_t p;
    case (fill)
      FILL_FULL: p = '1;
      FILL_CHECKER: begin
        if (((row_pos + col_pos) & 1) != 0) p = {8'hFF, 8'h00, 8'hFF};
        else p = {8'h00, 8'hFF, 8'h00};
      end
      default: begin
        p = 24'($urandom);
        // Saturated channels now and then, so that the sums reach their extremes.
        if ($urandom_range(0, 3) == 0) p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 3) == 0) p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 3) == 0) p.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
    endcase
    return p;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s mismatch at row %0d col %0d: got %0d, expected %0d",
                                name, oldest_expected.row, oldest_expected.col, got, want));
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      gap = bursty ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        pixel_bus.valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Offers one pixel and holds it until the block takes the beat.
  task automatic send_pixel(pixel_t px);
    pixel_bus.valid <= 1'b1;
    pixel_bus.red   <= px.red;
    pixel_bus.green <= px.green;
    pixel_bus.blue  <= px.blue;
    offering = 1'b1;
    do @(posedge clk); while (pixel_bus.ready !== 1'b1);
    predict_pixel(px);
    pixel_count++;
    pace_sender();
  endtask

  task automatic wait_until_idle();
    if (offering) begin
      pixel_bus.valid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_pixels.size() != 0) @(posedge clk);
    // Pixels that owe nothing, such as row zero of a frame taller than one row, may still be in flight.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both size registers as two back-to-back beats once the block has gone quiet.
  task automatic set_frame_size(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    wait_until_idle();
    config_bus.valid <= 1'b1;
    config_bus.index <= REG_IMAGE_WIDTH;
    config_bus.data  <= w;
    do @(posedge clk); while (config_bus.ready !== 1'b1);
    width_setting = w;
    config_bus.index <= REG_IMAGE_HEIGHT;
    config_bus.data  <= h;
    do @(posedge clk); while (config_bus.ready !== 1'b1);
    height_setting = h;
    config_bus.valid <= 1'b0;
  endtask

  task automatic drive_frame(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, fill_t fill);
    set_frame_size(w, h);
    do send_pixel(make_pixel(fill)); while (!at_frame_start());
  endtask

  // Begins at the reset size, narrows the frame part-way through row zero, then cuts the
  // height to zero (used as one) so that the current row becomes the last.
  task automatic test_mid_frame_resize();
    repeat (4) send_pixel(make_pixel(FILL_RANDOM));
    set_frame_size(2, RESET_HEIGHT);
    repeat (2) send_pixel(make_pixel(FILL_RANDOM));
    set_frame_size(2, 0);
    while (!at_frame_start()) send_pixel(make_pixel(FILL_RANDOM));
  endtask

  task automatic test_full_scale_mean();
    drive_frame(3, 3, FILL_FULL);
  endtask

  task automatic test_checkerboard();
    drive_frame(4, 3, FILL_CHECKER);
  endtask

  task automatic test_single_pixel_frames();
    drive_frame(0, 0, FILL_RANDOM);
    drive_frame(0, 0, FILL_RANDOM);
  endtask

  // The largest width value is taken as the maximum; the row is then cut short so that the
  // single-row frame ends after a few pixels.
  task automatic test_widest_row();
    set_frame_size(11'h7FF, 1);
    repeat (16) send_pixel(make_pixel(FILL_RANDOM));
    set_frame_size(2, 1);
    while (!at_frame_start()) send_pixel(make_pixel(FILL_RANDOM));
  endtask

  // A one-pixel column of the largest height, ended early by making the current row the last.
  task automatic test_tallest_column();
    set_frame_size(1, 11'h7FF);
    repeat (16) send_pixel(make_pixel(FILL_RANDOM));
    set_frame_size(1, 0);
    while (!at_frame_start()) send_pixel(make_pixel(FILL_RANDOM));
  endtask

  task automatic test_random_frames();
    int unsigned w, h, area, change_at, sent, first_count;
    first_count = pixel_count;
    while (pixel_count - first_count < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      set_frame_size(SIZE_W'(w), SIZE_W'(h));
      area = effective_size(width_setting, MAX_WIDTH) * effective_size(height_setting, MAX_HEIGHT);
      change_at = (area > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, area - 1) : 0;
      sent = 0;
      do begin
        // Mid-frame changes only narrow the row, so no unwritten line entry is ever read.
        if (change_at != 0 && sent == change_at)
          set_frame_size(SIZE_W'($urandom_range(0, effective_size(width_setting, MAX_WIDTH))),
                         SIZE_W'($urandom_range(0, 7)));
        send_pixel(make_pixel(FILL_RANDOM));
        sent++;
      end while (!at_frame_start());
    end
  endtask

  // The receiver stops for a long stretch while pixels keep coming, so the block backs up.
  task automatic test_long_stall();
    set_frame_size(6, 4);
    bursty = 1'b0;
    @(negedge clk);
    hold_request = 400;
    @(posedge clk);
    do send_pixel(make_pixel(FILL_RANDOM)); while (!at_frame_start());
    bursty = 1'b1;
  endtask

  // Receiver: picks a new stall style whenever the current one runs out, or holds off on request.
  initial begin
    int unsigned hold_left;
    int unsigned style_left;
    int unsigned stall_phase;
    ready_style_t stall_style;
    hold_left = 0;
    style_left = 0;
    stall_phase = 0;
    stall_style = READY_ALWAYS;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (style_left == 0) begin
        stall_style = ready_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(16, 96);
      end else begin
        style_left--;
      end
      stall_phase++;
      if (hold_left != 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        case (stall_style)
          READY_ALWAYS: result_bus.ready <= 1'b1;
          READY_MOSTLY: result_bus.ready <= ($urandom_range(0, 4) != 0);
          READY_SELDOM: result_bus.ready <= ($urandom_range(0, 3) == 0);
          default:      result_bus.ready <= stall_phase[1];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result at row %0d col %0d with nothing expected",
                                  result_bus.pixel_row, result_bus.pixel_col));
      end else begin
        oldest_expected = expected_pixels.pop_front();
        check_field("out_red", result_bus.out_red, oldest_expected.pixel.red);
        check_field("out_green", result_bus.out_green, oldest_expected.pixel.green);
        check_field("out_blue", result_bus.out_blue, oldest_expected.pixel.blue);
        check_field("pixel_row", result_bus.pixel_row, oldest_expected.row);
        check_field("pixel_col", result_bus.pixel_col, oldest_expected.col);
        check_field("frame_last", result_bus.frame_last, oldest_expected.frame_last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    pixel_bus.valid  <= 1'b0;
    pixel_bus.red    <= '0;
    pixel_bus.green  <= '0;
    pixel_bus.blue   <= '0;
    config_bus.valid <= 1'b0;
    config_bus.index <= REG_IMAGE_WIDTH;
    config_bus.data  <= '0;
    foreach (line_two_up[k]) begin
      line_two_up[k] = '0;
      line_one_up[k] = '0;
    end
    foreach (nbr_win[k]) nbr_win[k] = '0;
    col_pos = 0;
    row_pos = 0;
    width_setting = RESET_WIDTH;
    height_setting = RESET_HEIGHT;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_mid_frame_resize();
    test_full_scale_mean();
    test_checkerboard();
    test_single_pixel_frames();
    test_random_frames();
    test_long_stall();
    test_widest_row();
    test_tallest_column();

    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
